/* rtl/core/lifo_stack_with_peek_core_defines.svh */
// Assertion macros for the LIFO stack core.
// Clock and reset names follow the core: i_clk and i_rst_n.
`ifndef LIFO_STACK_WITH_PEEK_CORE_DEFINES_SVH
`define LIFO_STACK_WITH_PEEK_CORE_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define LSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lsp_pkg.sv */
// Shared constants for the LIFO stack core: field widths, command and
// status codes, default depth. No dependencies.
package lsp_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int POS_W     = 9;
    localparam int FILL_W    = 9;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    localparam logic [WORD_W-1:0] FAIL_WORD = '1;

endpackage

/* rtl/core/lsp_mem.sv */
// Stack word memory: one write port, one read port, registered read data.
// Depends on lsp_pkg for the word width.
module lsp_mem #(
    parameter int DEPTH = lsp_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [lsp_pkg::WORD_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [lsp_pkg::WORD_W-1:0] o_rdata
);

    logic [lsp_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [lsp_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lifo_stack_with_peek_core.sv */
// LIFO stack core with peek by position, top level.
// Input channel: i_in_valid / o_in_stall carry one item (command, value,
// position). An item is taken at a clock edge with i_in_valid high and
// o_in_stall low. Output channel: o_out_valid / i_out_stall carry one result
// (data, status, top word, empty flag, fill) for every item taken.
// One item is worked at a time; the next item is taken as soon as the
// sequencer is back in idle, even while the previous result still waits in
// the output register. Each item steps through the sequencer states: push,
// failed pop or peek, and unused codes go from idle straight to the output
// state; peek passes the data state, which takes the registered read of the
// word memory; pop does too and, unless it empties the stack, then the top
// state, where a second read fetches the new top word. The output state
// loads the result registers; it waits while i_out_stall holds a result.
// A push on a full stack flags overflow and changes nothing.
// Synchronous reset empties the stack and drops any pending result; memory
// contents are not cleared, as no entry is read before it is written.
// Depends on lsp_pkg, lsp_mem and lifo_stack_with_peek_core_defines.svh.
`include "lifo_stack_with_peek_core_defines.svh"

module lifo_stack_with_peek_core #(
    parameter int DEPTH = lsp_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [lsp_pkg::CMD_W-1:0]         i_command,
    input  logic signed [lsp_pkg::WORD_W-1:0] i_value,
    input  logic [lsp_pkg::POS_W-1:0]         i_position,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [lsp_pkg::WORD_W-1:0] o_data,
    output logic [lsp_pkg::STAT_W-1:0]        o_status,
    output logic signed [lsp_pkg::WORD_W-1:0] o_top_word,
    output logic                              o_empty_res,
    output logic [lsp_pkg::FILL_W-1:0]        o_fill
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > lsp_pkg::POS_W) ? CW : lsp_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DATA = 4'b0010,
        S_TOP  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [lsp_pkg::WORD_W-1:0]  r_top, n_top;
    logic [lsp_pkg::CMD_W-1:0]   r_cmd, n_cmd;
    logic [lsp_pkg::WORD_W-1:0]  r_data, n_data;
    logic [lsp_pkg::STAT_W-1:0]  r_status, n_status;

    logic                        r_out_valid, n_out_valid;
    logic [lsp_pkg::WORD_W-1:0]  r_out_data, n_out_data;
    logic [lsp_pkg::STAT_W-1:0]  r_out_status, n_out_status;
    logic [lsp_pkg::WORD_W-1:0]  r_out_top, n_out_top;
    logic                        r_out_empty, n_out_empty;
    logic [lsp_pkg::FILL_W-1:0]  r_out_fill, n_out_fill;

    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [lsp_pkg::WORD_W-1:0]  w_wdata;
    logic                        w_re;
    logic [AW-1:0]               w_raddr;
    logic [lsp_pkg::WORD_W-1:0]  w_rdata;

    logic [PW-1:0]               w_pos_eff;
    logic [PW-1:0]               w_cnt_ext;
    logic                        w_full;
    logic                        w_accept;

    lsp_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Position zero addresses the top.
    assign w_pos_eff = (i_position == '0) ? PW'(1) : PW'(i_position);
    assign w_cnt_ext = PW'(r_count);
    assign w_full    = (r_count == CW'(DEPTH));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_top        = r_top;
        n_cmd        = r_cmd;
        n_data       = r_data;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_top    = r_out_top;
        n_out_empty  = r_out_empty;
        n_out_fill   = r_out_fill;
        w_we         = 1'b0;
        w_waddr      = AW'(r_count);
        w_wdata      = i_value;
        w_re         = 1'b0;
        w_raddr      = AW'(r_count - CW'(1));

        // Drop the held result once the receiver takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_command;
                    n_data   = '0;
                    n_status = lsp_pkg::ST_OK;
                    n_state  = S_OUT;
                    case (i_command)
                        lsp_pkg::CMD_PUSH: begin
                            if (w_full) begin
                                n_status = lsp_pkg::ST_OVER;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CW'(1);
                                n_top   = i_value;
                            end
                        end
                        lsp_pkg::CMD_POP: begin
                            if (r_count == '0) begin
                                n_status = lsp_pkg::ST_UNDER;
                                n_data   = lsp_pkg::FAIL_WORD;
                            end else begin
                                w_re    = 1'b1;
                                n_count = r_count - CW'(1);
                                n_state = S_DATA;
                            end
                        end
                        lsp_pkg::CMD_PEEK: begin
                            if (w_pos_eff > w_cnt_ext) begin
                                n_status = lsp_pkg::ST_RANGE;
                                n_data   = lsp_pkg::FAIL_WORD;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = AW'(w_cnt_ext - w_pos_eff);
                                n_state = S_DATA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DATA: begin
                n_data = w_rdata;
                // After a pop that leaves entries, fetch the word now on top.
                if (r_cmd == lsp_pkg::CMD_POP && r_count != '0) begin
                    w_re    = 1'b1;
                    n_state = S_TOP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_TOP: begin
                n_top   = w_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_data;
                    n_out_status = r_status;
                    n_out_top    = (r_count == '0) ? lsp_pkg::FAIL_WORD : r_top;
                    n_out_empty  = (r_count == '0);
                    n_out_fill   = lsp_pkg::FILL_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_cmd        <= n_cmd;
        r_data       <= n_data;
        r_status     <= n_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_top    <= n_out_top;
        r_out_empty  <= n_out_empty;
        r_out_fill   <= n_out_fill;
    end

    assign o_out_valid = r_out_valid;
    assign o_data      = r_out_data;
    assign o_status    = r_out_status;
    assign o_top_word  = r_out_top;
    assign o_empty_res = r_out_empty;
    assign o_fill      = r_out_fill;

    `LSP_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "entry count above depth")
    `LSP_ASSERT_NEXT(a_push_grows, w_accept && i_command == lsp_pkg::CMD_PUSH && !w_full,
        r_count == $past(r_count) + CW'(1), "push did not add an entry")
    `LSP_ASSERT_NEXT(a_top_after_data, r_state == S_DATA && w_re,
        r_state == S_TOP, "new top read lost")
    `LSP_ASSERT(a_load_from_out, $rose(o_out_valid) |-> $past(r_state == S_OUT),
        "result loaded outside output state")
    `LSP_ASSERT(a_no_write_busy, w_we |-> r_state == S_IDLE && !w_full,
        "memory write outside an accepted push")

endmodule
